// ----- rtl/core/fcm_pkg.sv -----
// ----------------------------------------------------------------------------
// fcm_pkg
// Shared types and constants of the false color mapper pipeline.
// ----------------------------------------------------------------------------
package fcm_pkg;

  localparam int SAMPLE_W        = 16;
  localparam int COLOR_W         = 8;
  localparam int DIFF_W          = SAMPLE_W + 1;
  localparam int NUM_W           = 26;
  localparam int DEN_W           = 16;
  localparam int QUO_W           = 12;
  localparam int Q_W             = 12;
  localparam int DIV_STAGES      = 4;
  localparam int STEPS_PER_STAGE = 3;
  localparam int SCALE_STEPS     = 1020;
  localparam int FULL            = 255;
  localparam int Q_MAX           = 1024;
  localparam int CFG_IDX_W       = 2;

  localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_LOW  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_HIGH = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_COLOR_MODE  = 2'd2;

  localparam logic signed [SAMPLE_W-1:0] WINDOW_LOW_RESET  = 16'sd0;
  localparam logic signed [SAMPLE_W-1:0] WINDOW_HIGH_RESET = 16'sd32767;

  typedef enum logic [2:0] {
    REGION_ABOVE,
    REGION_UPPER_HALF,
    REGION_UPPER_QUARTER,
    REGION_LOWER_QUARTER,
    REGION_BELOW
  } region_t;

  typedef enum logic [1:0] {
    QSEL_ZERO,
    QSEL_NEG,
    QSEL_DIV
  } qsel_t;

  typedef struct packed {
    logic    mode;
    region_t region;
    qsel_t   qsel;
  } side_t;

  function automatic logic [COLOR_W-1:0] sat8(input logic signed [Q_W-1:0] v);
    logic [COLOR_W-1:0] res;
    if (v < 0) begin
      res = '0;
    end else if (v > FULL) begin
      res = COLOR_W'(FULL);
    end else begin
      res = v[COLOR_W-1:0];
    end
    return res;
  endfunction

endpackage

// ----- rtl/core/fcm_front.sv -----
// ----------------------------------------------------------------------------
// fcm_front
// Window offset, span, region classification, scaling by 1020 and sign split
// ahead of the divider.
// ----------------------------------------------------------------------------
module fcm_front (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  en,
  input  logic                                  in_valid,
  input  logic signed [fcm_pkg::SAMPLE_W-1:0]   sample,
  input  logic signed [fcm_pkg::SAMPLE_W-1:0]   win_low,
  input  logic signed [fcm_pkg::SAMPLE_W-1:0]   win_high,
  input  logic                                  mode,
  output logic                                  out_valid,
  output logic [fcm_pkg::NUM_W-1:0]             nmag,
  output logic [fcm_pkg::DEN_W-1:0]             dmag,
  output fcm_pkg::side_t                        side
);
  import fcm_pkg::*;

  logic signed [DIFF_W-1:0] diff_r, diff_nxt;
  logic signed [DIFF_W-1:0] span_r, span_nxt;
  region_t                  region_r, region_nxt;
  logic                     mode_r;
  logic                     v1_r;

  logic [NUM_W-1:0]         nmag_r, nmag_nxt;
  logic [DEN_W-1:0]         dmag_r, dmag_nxt;
  side_t                    side_r, side_nxt;
  logic                     v2_r;

  logic signed [17:0]       two_s;
  logic signed [17:0]       mid_sum;
  logic signed [18:0]       four_s;
  logic signed [18:0]       lo19;
  logic signed [18:0]       hi19;
  logic signed [18:0]       quarter_sum;
  logic signed [NUM_W:0]    d_ext;
  logic signed [NUM_W:0]    num;
  logic signed [NUM_W:0]    num_abs;
  logic signed [DIFF_W-1:0] span_abs;

  always_comb begin
    diff_nxt    = DIFF_W'(sample) - DIFF_W'(win_low);
    span_nxt    = DIFF_W'(win_high) - DIFF_W'(win_low);
    two_s       = 18'(sample) <<< 1;
    mid_sum     = 18'(win_high) + 18'(win_low);
    four_s      = 19'(sample) <<< 2;
    lo19        = 19'(win_low);
    hi19        = 19'(win_high);
    quarter_sum = (lo19 <<< 1) + lo19 + hi19;
    if (sample > win_high) begin
      region_nxt = REGION_ABOVE;
    end else if (two_s >= mid_sum) begin
      region_nxt = REGION_UPPER_HALF;
    end else if (four_s >= quarter_sum) begin
      region_nxt = REGION_UPPER_QUARTER;
    end else if (sample >= win_low) begin
      region_nxt = REGION_LOWER_QUARTER;
    end else begin
      region_nxt = REGION_BELOW;
    end
  end

  always_comb begin
    d_ext    = (NUM_W+1)'(diff_r);
    num      = (d_ext <<< 10) - (d_ext <<< 2);
    num_abs  = (num < 0) ? -num : num;
    span_abs = (span_r < 0) ? -span_r : span_r;
    nmag_nxt = num_abs[NUM_W-1:0];
    dmag_nxt = span_abs[DEN_W-1:0];
    side_nxt.mode   = mode_r;
    side_nxt.region = region_r;
    if (span_r == 0 || num == 0) begin
      side_nxt.qsel = QSEL_ZERO;
    end else if ((num < 0) != (span_r < 0)) begin
      side_nxt.qsel = QSEL_NEG;
    end else begin
      side_nxt.qsel = QSEL_DIV;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_valid;
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      diff_r   <= diff_nxt;
      span_r   <= span_nxt;
      region_r <= region_nxt;
      mode_r   <= mode;
      nmag_r   <= nmag_nxt;
      dmag_r   <= dmag_nxt;
      side_r   <= side_nxt;
    end
  end

  assign out_valid = v2_r;
  assign nmag      = nmag_r;
  assign dmag      = dmag_r;
  assign side      = side_r;

endmodule

// ----- rtl/core/fcm_divider.sv -----
// ----------------------------------------------------------------------------
// fcm_divider
// Restoring divider, three quotient steps per stage over four stages.
// The top quotient bit flags a quotient of 2048 or more.
// ----------------------------------------------------------------------------
module fcm_divider (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        en,
  input  logic                        in_valid,
  input  logic [fcm_pkg::NUM_W-1:0]   nmag,
  input  logic [fcm_pkg::DEN_W-1:0]   dmag,
  input  fcm_pkg::side_t              in_side,
  output logic                        out_valid,
  output logic [fcm_pkg::QUO_W-1:0]   quo,
  output fcm_pkg::side_t              out_side
);
  import fcm_pkg::*;

  logic [NUM_W-1:0] rem_in  [DIV_STAGES];
  logic [QUO_W-1:0] quo_in  [DIV_STAGES];
  logic [DEN_W-1:0] den_in  [DIV_STAGES];
  side_t            side_in [DIV_STAGES];
  logic             v_in    [DIV_STAGES];

  logic [NUM_W-1:0] rem_r   [DIV_STAGES];
  logic [QUO_W-1:0] quo_r   [DIV_STAGES];
  logic [DEN_W-1:0] den_r   [DIV_STAGES];
  side_t            side_r  [DIV_STAGES];
  logic             v_r     [DIV_STAGES];

  logic [NUM_W-1:0] rem_nxt [DIV_STAGES];
  logic [QUO_W-1:0] quo_nxt [DIV_STAGES];

  for (genvar j = 0; j < DIV_STAGES; j++) begin : g_stage
    if (j == 0) begin : g_first
      assign rem_in[j]  = nmag;
      assign quo_in[j]  = '0;
      assign den_in[j]  = dmag;
      assign side_in[j] = in_side;
      assign v_in[j]    = in_valid;
    end else begin : g_next
      assign rem_in[j]  = rem_r[j-1];
      assign quo_in[j]  = quo_r[j-1];
      assign den_in[j]  = den_r[j-1];
      assign side_in[j] = side_r[j-1];
      assign v_in[j]    = v_r[j-1];
    end

    always_comb begin
      logic [NUM_W:0]   trial;
      logic [NUM_W-1:0] rem;
      logic [QUO_W-1:0] q;
      rem = rem_in[j];
      q   = quo_in[j];
      for (int i = 0; i < STEPS_PER_STAGE; i++) begin
        trial = (NUM_W+1)'(den_in[j]) << (QUO_W - 1 - (j * STEPS_PER_STAGE + i));
        if ((NUM_W+1)'(rem) >= trial) begin
          rem = rem - trial[NUM_W-1:0];
          q[QUO_W - 1 - (j * STEPS_PER_STAGE + i)] = 1'b1;
        end
      end
      rem_nxt[j] = rem;
      quo_nxt[j] = q;
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[j] <= 1'b0;
      end else if (en) begin
        v_r[j] <= v_in[j];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[j]  <= rem_nxt[j];
        quo_r[j]  <= quo_nxt[j];
        den_r[j]  <= den_in[j];
        side_r[j] <= side_in[j];
      end
    end
  end

  assign out_valid = v_r[DIV_STAGES-1];
  assign quo       = quo_r[DIV_STAGES-1];
  assign out_side  = side_r[DIV_STAGES-1];

endmodule

// ----- rtl/core/fcm_color.sv -----
// ----------------------------------------------------------------------------
// fcm_color
// Clamps the scale position and maps it to gray or ocean colors; holds the
// output word.
// ----------------------------------------------------------------------------
module fcm_color (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          en,
  input  logic                          in_valid,
  input  logic [fcm_pkg::QUO_W-1:0]     quo,
  input  fcm_pkg::side_t                side,
  output logic                          out_valid,
  output logic [fcm_pkg::COLOR_W-1:0]   red,
  output logic [fcm_pkg::COLOR_W-1:0]   green,
  output logic [fcm_pkg::COLOR_W-1:0]   blue
);
  import fcm_pkg::*;

  logic signed [Q_W-1:0]  q;
  logic [COLOR_W-1:0]     red_nxt, green_nxt, blue_nxt;
  logic [COLOR_W-1:0]     red_r, green_r, blue_r;
  logic                   valid_r;

  // clamp q to -1..1024; every channel saturates the same way beyond that
  always_comb begin
    case (side.qsel)
      QSEL_ZERO: q = '0;
      QSEL_NEG:  q = -Q_W'(1);
      QSEL_DIV: begin
        if (quo[QUO_W-1] || quo[QUO_W-2:0] > (QUO_W-1)'(Q_MAX)) begin
          q = Q_W'(Q_MAX);
        end else begin
          q = Q_W'(quo[QUO_W-2:0]);
        end
      end
      default:   q = '0;
    endcase
  end

  always_comb begin
    red_nxt   = '0;
    green_nxt = '0;
    blue_nxt  = '0;
    if (!side.mode) begin
      red_nxt   = sat8(q >>> 2);
      green_nxt = red_nxt;
      blue_nxt  = red_nxt;
    end else begin
      case (side.region)
        REGION_ABOVE: begin
          red_nxt = COLOR_W'(FULL);
        end
        REGION_UPPER_HALF: begin
          red_nxt   = COLOR_W'(FULL);
          green_nxt = sat8((Q_W'(SCALE_STEPS) - q) >>> 1);
        end
        REGION_UPPER_QUARTER: begin
          red_nxt   = sat8(q - Q_W'(FULL));
          green_nxt = COLOR_W'(FULL);
        end
        REGION_LOWER_QUARTER: begin
          green_nxt = sat8(q);
          blue_nxt  = sat8(Q_W'(FULL) - q);
        end
        default: begin
          blue_nxt = COLOR_W'(FULL);
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (en) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      red_r   <= red_nxt;
      green_r <= green_nxt;
      blue_r  <= blue_nxt;
    end
  end

  assign out_valid = valid_r;
  assign red       = red_r;
  assign green     = green_r;
  assign blue      = blue_r;

endmodule

// ----- rtl/core/false_color_mapper_top.sv -----
// ----------------------------------------------------------------------------
// false_color_mapper_top
// Colorizes signed samples through a configurable window, gray or ocean ramp.
// ----------------------------------------------------------------------------
// Takes one sample word per clock while the output side is not stalled, and
// returns one color word per sample, in the order the samples were taken.
// The pipeline is two front stages (offset, span, region test, scaling),
// four stages of the restoring divider at three quotient bits each, and the
// color stage that holds the output word. A stall on the output freezes the
// whole pipeline, so in_tready follows out_tready while a word is waiting.
// Registers are written through the cfg port and take effect on samples
// accepted afterwards; write them only while no sample is in flight.
module false_color_mapper_top (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  input  logic [15:0]                        in_tdata,   // [15:0] sample
  output logic                               out_tvalid,
  input  logic                               out_tready,
  output logic [23:0]                        out_tdata,  // [7:0] red, [15:8] green, [23:16] blue
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [fcm_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [15:0]                        cfg_data
);
  import fcm_pkg::*;

  logic signed [SAMPLE_W-1:0] window_low_r;
  logic signed [SAMPLE_W-1:0] window_high_r;
  logic                       color_mode_r;
  logic                       en;

  logic                       front_valid;
  logic [NUM_W-1:0]           front_nmag;
  logic [DEN_W-1:0]           front_dmag;
  side_t                      front_side;

  logic                       div_valid;
  logic [QUO_W-1:0]           div_quo;
  side_t                      div_side;

  logic [COLOR_W-1:0]         red;
  logic [COLOR_W-1:0]         green;
  logic [COLOR_W-1:0]         blue;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      window_low_r  <= WINDOW_LOW_RESET;
      window_high_r <= WINDOW_HIGH_RESET;
      color_mode_r  <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_WINDOW_LOW:  window_low_r  <= cfg_data;
        CFG_WINDOW_HIGH: window_high_r <= cfg_data;
        CFG_COLOR_MODE:  color_mode_r  <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // advance the pipeline unless a result word is held
  assign en        = !out_tvalid || out_tready;
  assign in_tready = en;

  fcm_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (in_tvalid),
    .sample    (in_tdata),
    .win_low   (window_low_r),
    .win_high  (window_high_r),
    .mode      (color_mode_r),
    .out_valid (front_valid),
    .nmag      (front_nmag),
    .dmag      (front_dmag),
    .side      (front_side)
  );

  fcm_divider u_divider (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (front_valid),
    .nmag      (front_nmag),
    .dmag      (front_dmag),
    .in_side   (front_side),
    .out_valid (div_valid),
    .quo       (div_quo),
    .out_side  (div_side)
  );

  fcm_color u_color (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (div_valid),
    .quo       (div_quo),
    .side      (div_side),
    .out_valid (out_tvalid),
    .red       (red),
    .green     (green),
    .blue      (blue)
  );

  assign out_tdata = {blue, green, red};

`ifndef SYNTHESIS
  a_gray_equal: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !color_mode_r |-> (red == green) && (green == blue))
    else $error("gray word with unequal channels");

  a_ocean_mix: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && color_mode_r |-> (red == '0) || (blue == '0))
    else $error("ocean word mixes red and blue");

  a_reset_empty: assert property (@(posedge clk) disable iff (!rst_n)
    $past(!rst_n) |-> !out_tvalid)
    else $error("result word right after reset");
`endif

endmodule

// ----- tb/sv/tb_false_color_mapper_top.sv -----
// ----------------------------------------------------------------------------
// tb_false_color_mapper_top
// Self-checking stream test of the false color mapper. A color ledger predicts
// every accepted sample from its own copy of the window and mode registers.
// Each output word is checked, channel by channel, against the oldest
// prediction. A directed pass covers the window edges, every ocean region,
// a zero span and an inverted window. Random phases follow, each with a fresh
// register setting; both sides idle or stall at random, bar two steady phases.
// ----------------------------------------------------------------------------
module tb_false_color_mapper_top;

  import fcm_pkg::*;

  localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;
  localparam int STALL_LIMIT = 2000;
  localparam int RAND_PHASES = 10;
  localparam int PHASE_ITEMS = 125;

  typedef struct packed {
    logic [COLOR_W-1:0] blue;
    logic [COLOR_W-1:0] green;
    logic [COLOR_W-1:0] red;
  } rgb_t;

  class color_ledger;
    logic signed [SAMPLE_W-1:0] win_lo;
    logic signed [SAMPLE_W-1:0] win_hi;
    logic                       ocean;
    rgb_t                       pending_colors[$];
    int                         mismatches;

    function new();
      win_lo      = WINDOW_LOW_RESET;
      win_hi      = WINDOW_HIGH_RESET;
      ocean       = 1'b0;
      mismatches  = 0;
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [15:0] val);
      case (idx)
        CFG_WINDOW_LOW:  win_lo = signed'(val);
        CFG_WINDOW_HIGH: win_hi = signed'(val);
        CFG_COLOR_MODE:  ocean  = val[0];
        default: ;
      endcase
    endfunction

    function longint floor_div(longint n, longint d);
      longint q;
      q = n / d;
      if ((n % d) != 0 && ((n < 0) != (d < 0))) q--;
      return q;
    endfunction

    function logic [COLOR_W-1:0] clip8(longint v);
      if (v < 0) return '0;
      if (v > FULL) return COLOR_W'(FULL);
      return COLOR_W'(v);
    endfunction

    function rgb_t map_sample(logic signed [SAMPLE_W-1:0] smp);
      longint s, lo, hi, span, q, r, g, b;
      rgb_t   c;
      s    = smp;
      lo   = win_lo;
      hi   = win_hi;
      span = hi - lo;
      q    = 0;
      if (span != 0) q = floor_div(SCALE_STEPS * (s - lo), span);
      if (!ocean) begin
        r = floor_div(q, 4);
        g = r;
        b = r;
      end else if (s > hi) begin
        r = FULL; g = 0; b = 0;
      end else if (2 * s >= hi + lo) begin
        r = FULL; g = floor_div(SCALE_STEPS - q, 2); b = 0;
      end else if (4 * s >= 3 * lo + hi) begin
        r = q - FULL; g = FULL; b = 0;
      end else if (s >= lo) begin
        r = 0; g = q; b = FULL - q;
      end else begin
        r = 0; g = 0; b = FULL;
      end
      c.red   = clip8(r);
      c.green = clip8(g);
      c.blue  = clip8(b);
      return c;
    endfunction

    function void note_sample(logic [SAMPLE_W-1:0] smp);
      pending_colors.push_back(map_sample(signed'(smp)));
    endfunction

    function void check_color(rgb_t got);
      rgb_t want;
      if (pending_colors.size() == 0) begin
        $error("unexpected color word %h", got);
        mismatches++;
        return;
      end
      want = pending_colors.pop_front();
      if (got.red != want.red) begin
        $error("red: expected %0d, got %0d", want.red, got.red);
        mismatches++;
      end
      if (got.green != want.green) begin
        $error("green: expected %0d, got %0d", want.green, got.green);
        mismatches++;
      end
      if (got.blue != want.blue) begin
        $error("blue: expected %0d, got %0d", want.blue, got.blue);
        mismatches++;
      end
    endfunction
  endclass

  logic                 clk;
  logic                 rst_n;
  logic                 in_tvalid;
  logic                 in_tready;
  logic [15:0]          in_tdata;
  logic                 out_tvalid;
  logic                 out_tready;
  logic [23:0]          out_tdata;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [15:0]          cfg_data;

  color_ledger ledger;
  logic        steady;
  int          quiet_cycles;

  false_color_mapper_top DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) ledger.check_color(rgb_t'(out_tdata));
    out_tready <= steady ? 1'b1 : ($urandom_range(99) >= 7);
  end

  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready) ||
        (cfg_valid && cfg_ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("** false_color_mapper_top: FAILED **");
      $finish;
    end
  end

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    ledger.set_reg(idx, val);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_window(input int lo, input int hi, input logic ocean);
    write_reg(CFG_WINDOW_LOW, 16'(lo));
    write_reg(CFG_WINDOW_HIGH, 16'(hi));
    write_reg(CFG_COLOR_MODE, {15'($urandom), ocean});
  endtask

  task automatic send_sample(input logic [15:0] smp);
    if (!steady && $urandom_range(99) < 7) begin
      in_tvalid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < 7);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= smp;
    do @(posedge clk); while (!in_tready);
    ledger.note_sample(smp);
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (ledger.pending_colors.size() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  function automatic logic [15:0] pick_sample();
    longint a, b, m;
    if ($urandom_range(3) == 0) return 16'($urandom);
    a = (ledger.win_lo < ledger.win_hi) ? ledger.win_lo : ledger.win_hi;
    b = (ledger.win_lo < ledger.win_hi) ? ledger.win_hi : ledger.win_lo;
    m = (b - a) / 4 + 2;
    a = a - m;
    b = b + m;
    if (a < -32768) a = -32768;
    if (b > 32767) b = 32767;
    return 16'(a + $urandom_range(32'(b - a)));
  endfunction

  task automatic random_setting();
    int lo, hi;
    lo = $signed(16'($urandom));
    hi = $signed(16'($urandom));
    case ($urandom_range(4))
      0: ;
      1: begin
        hi = lo + $urandom_range(1, 2000);
        if (hi > 32767) hi = 32767;
      end
      2: begin
        lo = ($urandom_range(1) == 0) ? -32768 : 32767;
        hi = -1 - lo;
      end
      3: hi = lo;
      default: begin
        if (lo < hi) begin
          lo = hi;
          hi = lo - $urandom_range(1, 3000);
          if (hi < -32768) hi = -32768;
        end
      end
    endcase
    if ($urandom_range(3) == 0) write_reg(CFG_SPARE, 16'($urandom));
    set_window(lo, hi, 1'($urandom));
  endtask

  initial begin
    ledger       = new();
    steady       = 1'b0;
    rst_n        = 1'b0;
    in_tvalid    = 1'b0;
    in_tdata     = '0;
    cfg_valid    = 1'b0;
    cfg_index    = '0;
    cfg_data     = '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // gray ramp, reset window
    send_sample(16'h8000);
    send_sample(16'h7fff);
    send_sample(16'h0000);
    send_sample(16'hffff);
    drain();

    // ocean regions and their edges
    write_reg(CFG_SPARE, 16'hffff);
    set_window(-1000, 1000, 1'b1);
    send_sample(16'(1001));
    send_sample(16'(1000));
    send_sample(16'(0));
    send_sample(16'(-1));
    send_sample(16'(-500));
    send_sample(16'(-501));
    send_sample(16'(-1000));
    send_sample(16'(-1001));
    drain();

    // zero span
    set_window(5, 5, 1'b1);
    send_sample(16'(4));
    send_sample(16'(5));
    send_sample(16'(6));
    drain();

    // inverted window
    set_window(1000, -1000, 1'b1);
    send_sample(16'(0));
    send_sample(16'(1000));
    send_sample(16'(-1000));
    drain();

    // full-range window
    set_window(-32768, 32767, 1'b1);
    send_sample(16'h8000);
    send_sample(16'h7fff);
    send_sample(16'h0000);
    drain();

    for (int p = 0; p < RAND_PHASES; p++) begin
      steady = (p == 4 || p == 5);
      random_setting();
      for (int i = 0; i < PHASE_ITEMS; i++) send_sample(pick_sample());
      drain();
    end
    steady = 1'b0;

    repeat (16) @(posedge clk);
    if (ledger.mismatches == 0 && ledger.pending_colors.size() == 0) begin
      $display("** false_color_mapper_top: PASSED **");
    end else begin
      $display("** false_color_mapper_top: FAILED **");
    end
    $finish;
  end

endmodule
